/* rtl/card_id_whitelist_table_macros.svh */
// Assertion macros shared by the whitelist table RTL.
`ifndef CARD_ID_WHITELIST_TABLE_MACROS_SVH
`define CARD_ID_WHITELIST_TABLE_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define CWL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Cause in one cycle implies effect in the next.
`define CWL_ASSERT_NEXT(lbl, clk, rst, cause, effect, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) else $error(msg);

`endif

/* rtl/cwl_pkg.sv */
`default_nettype none
package cwl_pkg;

   localparam int ID_W       = 32;
   localparam int FUNC_W     = 2;
   localparam int SLOT_W     = 6;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 7;
   // wide enough for any table position up to the largest supported table
   localparam int SLOT_MAX_W = 10;

   localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

   // Search token that walks the row of cells, one cell per cycle.
   typedef struct packed {
      logic                  active;
      logic                  found;
      logic [SLOT_MAX_W-1:0] where;
      logic [ID_W-1:0]       rid;
   } token_type;

endpackage
`default_nettype wire

/* rtl/cwl_cell.sv */
`default_nettype none
module cwl_cell #(
   parameter int CNT_W    = 7,
   parameter int CELL_IDX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cwl_pkg::token_type           tok_up,
   output cwl_pkg::token_type           tok_down,
   input  logic [cwl_pkg::FUNC_W-1:0]   op_func,
   input  logic [cwl_pkg::ID_W-1:0]     op_id,
   input  logic [cwl_pkg::SLOT_W-1:0]   op_slot,
   input  logic [CNT_W-1:0]             op_count,
   input  logic [cwl_pkg::ID_W-1:0]     next_entry,
   output logic [cwl_pkg::ID_W-1:0]     entry
);
   import cwl_pkg::*;

   logic [ID_W-1:0] entry_ff, entry_in;
   token_type       tok_ff, tok_in;
   logic            in_table;
   logic            match;
   logic            found_now;

   assign in_table = (CELL_IDX < int'(op_count));
   assign match    = tok_up.active && (op_func != FUNC_READ) && in_table &&
                     (entry_ff == op_id) && !tok_up.found;
   assign found_now = tok_up.found | match;

   always_comb begin
      tok_in.active = tok_up.active;
      tok_in.found  = found_now;
      tok_in.where  = match ? SLOT_MAX_W'(CELL_IDX) : tok_up.where;
      tok_in.rid    = tok_up.rid;
      if (tok_up.active && (op_func == FUNC_READ) && in_table &&
          (int'(op_slot) == CELL_IDX)) begin
         tok_in.rid = entry_ff;
      end
   end

   // The neighbour above is still untouched when the token sits here, so a
   // delete pulls its word down one place.
   always_comb begin
      entry_in = entry_ff;
      if (tok_up.active) begin
         case (op_func)
            FUNC_ADD: begin
               if ((CELL_IDX == int'(op_count)) && !found_now) begin
                  entry_in = op_id;
               end
            end
            FUNC_DELETE: begin
               if (found_now) begin
                  entry_in = next_entry;
               end
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_down = tok_ff;
   assign entry    = entry_ff;

endmodule
`default_nettype wire

/* rtl/card_id_whitelist_table.sv */
// Card ID whitelist table: an ordered list of up to MAX_IDS 32-bit card IDs
// held one per cell in a row of cells. Each request (find, add, delete or
// read) launches a token that walks the row one cell per clock, comparing,
// appending or shifting entries down as it passes. An accepted request is
// registered to start the token, the token walks the row, the result is
// settled into the done registers and then moved to the output register.
// One request is in the row at a time; a new one is taken as soon as the
// previous response has moved to the output register, even while that
// response is stalled.
`default_nettype none
`include "card_id_whitelist_table_macros.svh"
module card_id_whitelist_table #(
   parameter int MAX_IDS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [cwl_pkg::FUNC_W-1:0]     req_func,
   input  logic [cwl_pkg::ID_W-1:0]       req_card_id,
   input  logic [cwl_pkg::SLOT_W-1:0]     req_slot_index,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [cwl_pkg::STATUS_W-1:0]   rsp_status,
   output logic                           rsp_hit,
   output logic [cwl_pkg::SLOT_W-1:0]     rsp_found_slot,
   output logic [cwl_pkg::COUNT_W-1:0]    rsp_entry_count,
   output logic [cwl_pkg::ID_W-1:0]       rsp_read_id
);
   import cwl_pkg::*;

   localparam int CNT_W = $clog2(MAX_IDS + 1);

   logic                  busy_ff;
   logic                  start_ff;
   logic                  done_ff;
   logic                  rsp_valid_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [FUNC_W-1:0]     func_ff;
   logic [ID_W-1:0]       id_ff;
   logic [SLOT_W-1:0]     slot_ff;

   logic [STATUS_W-1:0]   done_status_ff, done_status_in;
   logic                  done_hit_ff, done_hit_in;
   logic [SLOT_W-1:0]     done_slot_ff, done_slot_in;
   logic [ID_W-1:0]       done_rid_ff, done_rid_in;

   logic [STATUS_W-1:0]   rsp_status_ff;
   logic                  rsp_hit_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic [ID_W-1:0]       rsp_rid_ff;

   logic                  accept;
   logic                  move_out;
   token_type             tok [MAX_IDS+1];
   logic [ID_W-1:0]       entries [MAX_IDS];
   logic [MAX_IDS:0]      tok_act;
   token_type             fin;
   logic                  read_ok;

   assign req_stall = busy_ff;
   assign accept    = req_valid && !req_stall;
   assign move_out  = done_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      tok[0]        = '0;
      tok[0].active = start_ff;
   end

   for (genvar k = 0; k < MAX_IDS; k++) begin : g_row
      logic [ID_W-1:0] nxt;
      if (k == MAX_IDS - 1) begin : g_last
         assign nxt = entries[k];
      end else begin : g_mid
         assign nxt = entries[k+1];
      end
      cwl_cell #(
         .CNT_W    (CNT_W),
         .CELL_IDX (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .tok_up     (tok[k]),
         .tok_down   (tok[k+1]),
         .op_func    (func_ff),
         .op_id      (id_ff),
         .op_slot    (slot_ff),
         .op_count   (count_ff),
         .next_entry (nxt),
         .entry      (entries[k])
      );
   end

   for (genvar k = 0; k <= MAX_IDS; k++) begin : g_act
      assign tok_act[k] = tok[k].active;
   end

   assign fin     = tok[MAX_IDS];
   assign read_ok = (int'(slot_ff) < int'(count_ff));

   // Settle the result as the token leaves the row; count still holds the
   // value from before this word.
   always_comb begin
      done_status_in = ST_OK;
      done_hit_in    = 1'b0;
      done_slot_in   = '0;
      done_rid_in    = '0;
      count_in       = count_ff;
      case (func_ff)
         FUNC_READ: begin
            if (read_ok) begin
               done_rid_in = fin.rid;
            end else begin
               done_status_in = ST_RANGE;
            end
         end
         FUNC_ADD: begin
            done_hit_in = fin.found;
            if (fin.found) begin
               done_status_in = ST_DUP;
            end else if (count_ff >= CNT_W'(MAX_IDS)) begin
               done_status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         FUNC_DELETE: begin
            done_hit_in = fin.found;
            if (fin.found) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               done_status_in = ST_MISSING;
            end
         end
         default: begin
            done_hit_in = fin.found;
         end
      endcase
      if (done_hit_in) begin
         done_slot_in = fin.where[SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         start_ff <= accept;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (move_out) begin
            busy_ff <= 1'b0;
         end
         if (fin.active) begin
            done_ff  <= 1'b1;
            count_ff <= count_in;
         end else if (move_out) begin
            done_ff <= 1'b0;
         end
         if (move_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         id_ff   <= req_card_id;
         slot_ff <= req_slot_index;
      end
      if (fin.active) begin
         done_status_ff <= done_status_in;
         done_hit_ff    <= done_hit_in;
         done_slot_ff   <= done_slot_in;
         done_rid_ff    <= done_rid_in;
      end
      if (move_out) begin
         rsp_status_ff <= done_status_ff;
         rsp_hit_ff    <= done_hit_ff;
         rsp_slot_ff   <= done_slot_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
         rsp_rid_ff    <= done_rid_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_found_slot  = rsp_slot_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_read_id     = rsp_rid_ff;

   `CWL_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_IDS), "count above table size")
   `CWL_ASSERT(a_one_token, clock, reset, $countones(tok_act) <= 1, "two tokens in the row")
   `CWL_ASSERT(a_done_busy, clock, reset, (done_ff || fin.active) |-> busy_ff, "result without word")
   `CWL_ASSERT_NEXT(a_move_frees, clock, reset, move_out, rsp_valid_ff && !busy_ff, "result lost")
   `CWL_ASSERT(a_rid_zero, clock, reset, (rsp_valid_ff && rsp_status_ff != ST_OK) |-> rsp_rid_ff == '0, "read id on error")

endmodule
`default_nettype wire
